// ===== rtl/core/flm_pkg.sv =====
// ----------------------------------------------------------------------------
// flm_pkg
// Shared types and codes for the free list link manager.
// ----------------------------------------------------------------------------
package flm_pkg;

    // Width of a node index as carried on the ports and in the link memories
    localparam int IDX_W  = 8;

    // One link: a node index with a none flag
    typedef struct packed {
        logic             none;
        logic [IDX_W-1:0] idx;
    } t_link;

    localparam t_link LINK_NONE = '{none: 1'b1, idx: '0};

    // Command codes; the unused codes behave as a query
    typedef enum logic [2:0] {
        CMD_PREPEND = 3'd0,
        CMD_APPEND  = 3'd1,
        CMD_REMOVE  = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MODIFY,
        ST_WRITE2,
        ST_READBACK,
        ST_RESULT
    } t_state;

endpackage

// ===== rtl/core/flm_link_ram.sv =====
// ----------------------------------------------------------------------------
// flm_link_ram
// One link memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module flm_link_ram
    import flm_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_link         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_link         o_rdata
);

    t_link r_mem [DEPTH];
    t_link r_rdata;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data, hold it between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/free_list_link_manager_core.sv =====
// ----------------------------------------------------------------------------
// free_list_link_manager_core
// Doubly linked free list over a pool of node indices, with head and tail.
//
//   channel   direction  signals                                  handshake
//   request   in         i_cmd, i_node_index                      start & !busy
//   result    out        o_head_*, o_tail_*, o_link_*, o_*_none   o_done pulse
//
// A request is taken when start is high and busy is low; its node's links are
// read in that same cycle. The sequencer then passes through ST_MODIFY for the
// modify write, ST_WRITE2 for a second write on an in-pool prepend or append
// to a non-empty list, ST_READBACK to read the node back, and ST_RESULT to
// show the result; busy drops in the result state so the next request enters
// there. The single write port of each link memory costs the ST_WRITE2 state,
// and the registered read costs the ST_READBACK state. Reset (synchronous,
// active low) empties the list; link memories are not cleared. The receiver
// cannot stall.
// ----------------------------------------------------------------------------
module free_list_link_manager_core
    import flm_pkg::*;
#(
    parameter int NODES = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_cmd,
    input  logic [IDX_W-1:0] i_node_index,
    output logic             o_done,
    output logic [IDX_W-1:0] o_head_index,
    output logic             o_head_none,
    output logic [IDX_W-1:0] o_tail_index,
    output logic             o_tail_none,
    output logic [IDX_W-1:0] o_link_prev,
    output logic             o_prev_none,
    output logic [IDX_W-1:0] o_link_next,
    output logic             o_next_none
);

    // Only indices below 2**IDX_W are reachable
    localparam int DEPTH = (NODES < (1 << IDX_W)) ? NODES : (1 << IDX_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    function automatic logic f_in_pool(input logic [IDX_W-1:0] a);
        return 32'(a) < NODES;
    endfunction

    t_state           r_state, n_state;
    logic [2:0]       r_cmd, n_cmd;
    logic [IDX_W-1:0] r_node, n_node;
    logic             r_ok, n_ok;
    t_link            r_head, n_head;
    t_link            r_tail, n_tail;

    logic             accept;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    t_link            prev_rd, next_rd;

    logic             prev_we, next_we;
    logic [IDX_W-1:0] prev_waddr, next_waddr;
    t_link            prev_wdata, next_wdata;
    logic             need_wr2;

    assign accept = start && !busy;

    // Read the node on acceptance and again after the writes
    assign rd_en   = accept || (r_state == ST_READBACK);
    assign rd_addr = accept ? i_node_index : r_node;

    flm_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we && f_in_pool(prev_waddr)),
        .i_waddr (prev_waddr[AW-1:0]),
        .i_wdata (prev_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (prev_rd)
    );

    flm_link_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we && f_in_pool(next_waddr)),
        .i_waddr (next_waddr[AW-1:0]),
        .i_wdata (next_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr[AW-1:0]),
        .o_rdata (next_rd)
    );

    // Prepend or append to a non-empty list rewrites the node twice
    assign need_wr2 = r_ok && !r_head.none
                      && ((r_cmd == CMD_PREPEND) || (r_cmd == CMD_APPEND));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                n_state = need_wr2 ? ST_WRITE2 : ST_READBACK;
            end
            ST_WRITE2: begin
                n_state = ST_READBACK;
            end
            ST_READBACK: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                n_state = accept ? ST_MODIFY : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Latch the request
    always_comb begin
        n_cmd  = r_cmd;
        n_node = r_node;
        n_ok   = r_ok;
        if (accept) begin
            n_cmd  = i_cmd;
            n_node = i_node_index;
            n_ok   = f_in_pool(i_node_index);
        end
    end

    // Link writes and head/tail updates
    always_comb begin
        prev_we    = 1'b0;
        next_we    = 1'b0;
        prev_waddr = r_node;
        next_waddr = r_node;
        prev_wdata = LINK_NONE;
        next_wdata = LINK_NONE;
        n_head     = r_head;
        n_tail     = r_tail;
        case (r_state)
            ST_MODIFY: begin
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_head = LINK_NONE;
                        n_tail = LINK_NONE;
                    end
                    CMD_PREPEND, CMD_APPEND: begin
                        if (r_ok) begin
                            if (r_head.none) begin
                                // Empty list: node becomes head and tail
                                n_head  = '{none: 1'b0, idx: r_node};
                                n_tail  = '{none: 1'b0, idx: r_node};
                                prev_we = 1'b1;
                                next_we = 1'b1;
                            end else if (r_cmd == CMD_PREPEND) begin
                                prev_we    = 1'b1;
                                prev_waddr = r_head.idx;
                                prev_wdata = '{none: 1'b0, idx: r_node};
                                next_we    = 1'b1;
                                next_wdata = r_head;
                                n_head     = '{none: 1'b0, idx: r_node};
                            end else begin
                                next_we    = !r_tail.none;
                                next_waddr = r_tail.idx;
                                next_wdata = '{none: 1'b0, idx: r_node};
                                prev_we    = 1'b1;
                                prev_wdata = r_tail;
                                n_tail     = '{none: 1'b0, idx: r_node};
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_ok) begin
                            // Move head or tail past the node
                            if (!r_head.none && (r_head.idx == r_node)) begin
                                n_head = next_rd;
                            end
                            if (!r_tail.none && (r_tail.idx == r_node)) begin
                                n_tail = prev_rd;
                            end
                            // Relink the neighbours
                            next_we    = !prev_rd.none;
                            next_waddr = prev_rd.idx;
                            next_wdata = next_rd;
                            prev_we    = !next_rd.none;
                            prev_waddr = next_rd.idx;
                            prev_wdata = prev_rd;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_WRITE2: begin
                // Terminate the open end of the inserted node
                if (r_cmd == CMD_PREPEND) begin
                    prev_we = 1'b1;
                end else begin
                    next_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= LINK_NONE;
            r_tail  <= LINK_NONE;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_node <= n_node;
        r_ok   <= n_ok;
    end

    // Drive handshake and result
    assign busy         = (r_state != ST_IDLE) && (r_state != ST_RESULT);
    assign o_done       = (r_state == ST_RESULT);
    assign o_head_index = r_head.none ? '0 : r_head.idx;
    assign o_head_none  = r_head.none;
    assign o_tail_index = r_tail.none ? '0 : r_tail.idx;
    assign o_tail_none  = r_tail.none;
    assign o_link_prev  = (r_ok && !prev_rd.none) ? prev_rd.idx : '0;
    assign o_prev_none  = !r_ok || prev_rd.none;
    assign o_link_next  = (r_ok && !next_rd.none) ? next_rd.idx : '0;
    assign o_next_none  = !r_ok || next_rd.none;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for free_list_link_manager_core. A queue of requests
// is built up front: a directed opening over the edge cases, then random
// episodes of mostly well-formed list traffic with some malformed requests.
// A shadow copy of the list predicts head, tail and node links for each
// accepted request, and every o_done result is compared against it.
// ----------------------------------------------------------------------------
module testbench;
    import flm_pkg::*;

    localparam int NODES        = 256;
    localparam int RANDOM_ITEMS = 900;
    // Command codes outside the enum; the block treats them as a query
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct {
        logic [2:0]       cmd;
        logic [IDX_W-1:0] node;
        int               idle_pct;
    } t_request;

    typedef struct packed {
        t_link head;
        t_link tail;
        t_link pred;
        t_link succ;
    } t_snapshot;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       i_cmd;
    logic [IDX_W-1:0] i_node_index;
    logic             o_done;
    logic [IDX_W-1:0] o_head_index;
    logic             o_head_none;
    logic [IDX_W-1:0] o_tail_index;
    logic             o_tail_none;
    logic [IDX_W-1:0] o_link_prev;
    logic             o_prev_none;
    logic [IDX_W-1:0] o_link_next;
    logic             o_next_none;

    // Stimulus bookkeeping
    t_request         request_q[$];
    int               planned_cnt = 0;
    int               issued_cnt = 0;
    int               accepted_cnt = 0;
    int               err_cnt = 0;
    bit               ever_inserted[NODES];
    int               inserted_q[$];
    bit               on_list[NODES];
    int               on_list_q[$];

    // Shadow list state and expected results
    t_link            pred_mem[NODES];
    t_link            succ_mem[NODES];
    t_link            list_head = LINK_NONE;
    t_link            list_tail = LINK_NONE;
    t_snapshot        snapshot_q[$];

    free_list_link_manager_core #(
        .NODES(NODES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_node_index(i_node_index),
        .o_done      (o_done),
        .o_head_index(o_head_index),
        .o_head_none (o_head_none),
        .o_tail_index(o_tail_index),
        .o_tail_none (o_tail_none),
        .o_link_prev (o_link_prev),
        .o_prev_none (o_prev_none),
        .o_link_next (o_link_next),
        .o_next_none (o_next_none)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Force the index to zero whenever the none flag is set
    function automatic t_link shown(input t_link l);
        return l.none ? LINK_NONE : l;
    endfunction

    // Apply one request to the shadow list and return what the block shows
    task automatic apply_list_request(input logic [2:0] cmd, input logic [IDX_W-1:0] n,
                                      output t_snapshot snap);
        t_link p;
        t_link x;
        t_link self;
        p    = pred_mem[n];
        x    = succ_mem[n];
        self = '{none: 1'b0, idx: n};
        case (cmd)
            CMD_CLEAR: begin
                list_head = LINK_NONE;
                list_tail = LINK_NONE;
            end
            CMD_PREPEND, CMD_APPEND: begin
                if (list_head.none) begin
                    list_head   = self;
                    list_tail   = self;
                    pred_mem[n] = LINK_NONE;
                    succ_mem[n] = LINK_NONE;
                end else if (cmd == CMD_PREPEND) begin
                    pred_mem[list_head.idx] = self;
                    succ_mem[n] = list_head;
                    pred_mem[n] = LINK_NONE;
                    list_head   = self;
                end else begin
                    if (!list_tail.none) succ_mem[list_tail.idx] = self;
                    pred_mem[n] = shown(list_tail);
                    succ_mem[n] = LINK_NONE;
                    list_tail   = self;
                end
            end
            CMD_REMOVE: begin
                // Neighbors come from the links read before any update
                if (!list_head.none && list_head.idx == n) list_head = shown(x);
                if (!list_tail.none && list_tail.idx == n) list_tail = shown(p);
                if (!p.none) succ_mem[p.idx] = shown(x);
                if (!x.none) pred_mem[x.idx] = shown(p);
            end
            default: begin
                // query: no change
            end
        endcase
        snap.head = shown(list_head);
        snap.tail = shown(list_tail);
        snap.pred = shown(pred_mem[n]);
        snap.succ = shown(succ_mem[n]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    // Add a request to the plan and track which nodes are written and listed
    task automatic queue_request(input logic [2:0] cmd, input logic [IDX_W-1:0] node,
                                 input int idle);
        int i;
        request_q.push_back('{cmd: cmd, node: node, idle_pct: idle});
        planned_cnt++;
        case (cmd)
            CMD_PREPEND, CMD_APPEND: begin
                if (!ever_inserted[node]) begin
                    ever_inserted[node] = 1'b1;
                    inserted_q.push_back(node);
                end
                if (!on_list[node]) begin
                    on_list[node] = 1'b1;
                    on_list_q.push_back(node);
                end
            end
            CMD_REMOVE: begin
                if (on_list[node]) begin
                    on_list[node] = 1'b0;
                    for (i = 0; i < on_list_q.size(); i++) begin
                        if (on_list_q[i] == node) begin
                            on_list_q.delete(i);
                            break;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                on_list = '{default: 1'b0};
                on_list_q.delete();
            end
            default: begin
            end
        endcase
    endtask

    // Pick a node whose links have been written at least once
    function automatic logic [IDX_W-1:0] any_inserted();
        return IDX_W'(inserted_q[$urandom_range(0, inserted_q.size() - 1)]);
    endfunction

    // Sender idle percentage for each quarter of the random traffic
    function automatic int idle_for(input int k);
        case ((k * 4) / RANDOM_ITEMS)
            0:       return 0;
            1:       return 64;
            2:       return 0;
            default: return 15;
        endcase
    endfunction

    // Drive requests at the falling edge; hold each one until it is taken
    always @(negedge i_clk) begin : drive
        t_request req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && accepted_cnt != issued_cnt) begin
            // hold the current request
        end else if (request_q.size() != 0 &&
                     $urandom_range(0, 99) >= request_q[0].idle_pct) begin
            req = request_q.pop_front();
            start        <= 1'b1;
            i_cmd        <= req.cmd;
            i_node_index <= req.node;
            issued_cnt++;
        end else begin
            start <= 1'b0;
        end
    end

    // Check results and predict accepted requests at the rising edge
    always @(posedge i_clk) begin : observe
        t_snapshot got;
        t_snapshot want;
        if (i_rst_n) begin
            if (o_done) begin
                got.head = '{none: o_head_none, idx: o_head_index};
                got.tail = '{none: o_tail_none, idx: o_tail_index};
                got.pred = '{none: o_prev_none, idx: o_link_prev};
                got.succ = '{none: o_next_none, idx: o_link_next};
                if (snapshot_q.size() == 0) begin
                    $display("%0t: result with no request outstanding", $time);
                    err_cnt++;
                end else begin
                    want = snapshot_q.pop_front();
                    check_field("head_index", want.head.idx, got.head.idx);
                    check_field("head_none", want.head.none, got.head.none);
                    check_field("tail_index", want.tail.idx, got.tail.idx);
                    check_field("tail_none", want.tail.none, got.tail.none);
                    check_field("link_prev", want.pred.idx, got.pred.idx);
                    check_field("prev_none", want.pred.none, got.pred.none);
                    check_field("link_next", want.succ.idx, got.succ.idx);
                    check_field("next_none", want.succ.none, got.succ.none);
                end
            end
            if (start && !busy) begin
                apply_list_request(i_cmd, i_node_index, want);
                snapshot_q.push_back(want);
                accepted_cnt++;
            end
        end
    end

    // Build the request plan, apply reset, then wait for the run to drain
    initial begin : stimulus
        int               n_directed;
        int               roll;
        int               len;
        int               base;
        int               span;
        int               idle;
        int               sub;
        logic [IDX_W-1:0] node;
        logic [IDX_W-1:0] w;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = CMD_QUERY;
        i_node_index = '0;
        foreach (pred_mem[i]) begin
            pred_mem[i] = '0;
            succ_mem[i] = '0;
        end

        // Directed: empty-list inserts, head/middle/tail removal, duplicates
        queue_request(CMD_PREPEND, 8'd0, 0);
        queue_request(CMD_QUERY, 8'd0, 0);
        queue_request(CMD_APPEND, 8'd255, 0);
        queue_request(CMD_PREPEND, 8'd128, 0);
        queue_request(CMD_APPEND, 8'd1, 0);
        queue_request(CMD_QUERY, 8'd255, 0);
        queue_request(CMD_RSVD5, 8'd128, 0);
        queue_request(CMD_RSVD5 + 3'd1, 8'd0, 0);
        queue_request(CMD_RSVD7, 8'd1, 0);
        queue_request(CMD_REMOVE, 8'd0, 0);
        queue_request(CMD_REMOVE, 8'd128, 0);
        queue_request(CMD_REMOVE, 8'd1, 0);
        queue_request(CMD_REMOVE, 8'd255, 0);
        queue_request(CMD_APPEND, 8'd127, 0);
        queue_request(CMD_APPEND, 8'd127, 0);
        queue_request(CMD_REMOVE, 8'd0, 0);
        queue_request(CMD_CLEAR, 8'd127, 0);
        queue_request(CMD_QUERY, 8'd127, 0);
        queue_request(CMD_PREPEND, 8'd85, 0);
        queue_request(CMD_APPEND, 8'd170, 0);
        queue_request(CMD_PREPEND, 8'd85, 0);
        queue_request(CMD_REMOVE, 8'd85, 0);
        queue_request(CMD_REMOVE, 8'd85, 0);
        queue_request(CMD_CLEAR, 8'd170, 0);
        n_directed = planned_cnt;

        // Random episodes: clear, then traffic over a small or full pool
        while (planned_cnt - n_directed < RANDOM_ITEMS) begin
            idle = idle_for(planned_cnt - n_directed);
            if ($urandom_range(0, 4) == 0) begin
                base = 0;
                span = NODES;
            end else begin
                base = $urandom_range(0, NODES - 1);
                span = $urandom_range(2, 16);
            end
            queue_request(CMD_CLEAR, any_inserted(), idle);
            len = $urandom_range(8, 60);
            repeat (len) begin
                roll = $urandom_range(0, 99);
                node = IDX_W'(base + $urandom_range(0, span - 1));
                if (roll < 40) begin
                    if (!on_list[node])
                        queue_request($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND,
                                      node, idle);
                    else
                        queue_request(CMD_QUERY, node, idle);
                end else if (roll < 72 && on_list_q.size() != 0) begin
                    queue_request(CMD_REMOVE,
                                  IDX_W'(on_list_q[$urandom_range(0, on_list_q.size() - 1)]),
                                  idle);
                end else if (roll < 90) begin
                    queue_request(CMD_QUERY, ever_inserted[node] ? node : any_inserted(), idle);
                end else begin
                    // Malformed traffic: duplicate insert, stale remove, spare code, clear
                    sub = $urandom_range(0, 3);
                    w   = any_inserted();
                    case (sub)
                        0: begin
                            if (on_list_q.size() != 0)
                                w = IDX_W'(on_list_q[$urandom_range(0, on_list_q.size() - 1)]);
                            queue_request($urandom_range(0, 1) ? CMD_APPEND : CMD_PREPEND,
                                          w, idle);
                        end
                        1: queue_request(on_list[w] ? CMD_QUERY : CMD_REMOVE, w, idle);
                        2: queue_request(CMD_RSVD5 + 3'($urandom_range(0, 2)), w, idle);
                        default: queue_request(CMD_CLEAR, w, idle);
                    endcase
                end
            end
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: all requests taken, all results seen, then a short tail
        while (request_q.size() != 0 || accepted_cnt != issued_cnt) @(negedge i_clk);
        while (snapshot_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/flm_pkg.sv
rtl/core/flm_link_ram.sv
rtl/core/free_list_link_manager_core.sv
sim/testbench.sv
